[rtl/rxsd_pkg.sv]
// Shared types and constants for the descending record sort block.
package rxsd_pkg;

	localparam int ID_W = 31;
	localparam int SCORE_W = 10;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1000;

	typedef struct packed {
		logic [ID_W-1:0]    student_id;
		logic [SCORE_W-1:0] score;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    student_id_res;
		logic [SCORE_W-1:0] score_res;
		logic               last_res;
		logic               overflow;
	} res_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_I,
		ST_LD_I,
		ST_RD_J,
		ST_CMP,
		ST_EMIT
	} state_t;

endpackage

[rtl/rxsd_store.sv]
// Record store: one write port, one read port with registered read data.
module rxsd_store
	import rxsd_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/rxsd_cmpx.sv]
// Compare-exchange unit: keeps the higher-scoring record, spills the other.
module rxsd_cmpx
	import rxsd_pkg::*;
(
	input  rec_t held,
	input  rec_t cand,
	output logic swap,
	output rec_t keep,
	output rec_t spill
);

	// Strict less-than keeps the tie order of the exchange pass.
	assign swap  = held.score < cand.score;
	assign keep  = swap ? cand : held;
	assign spill = swap ? held : cand;

endmodule

[rtl/record_exchange_sort_desc_top.sv]
// Top level of the descending exchange sort: loader, sequencer and result output.
//
//  channel   signals                 handshake
//  --------  ----------------------  -------------------------------------------
//  input     din (in_item_t)         accepted on clk edge with start=1, busy=0
//  result    dout (res_item_t)       dout_valid strobe, one cycle per record
//
// A non-last record is written into the store when it is accepted and fits; busy stays low.
// A last record starts the sort: for each slot i, record i is read, then each
// later record is read and compared in turn, set by the store's single read port
// and the one compare-exchange unit. Record i is emitted once its scan ends.
// Reset clears the record count and the overflow flag; the store needs no clear.
// The receiver cannot stall; each result is shown for exactly one cycle.
module record_exchange_sort_desc_top
	import rxsd_pkg::*;
#(
	parameter int MAX_RECORDS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  din,
	output logic      busy,
	output logic      dout_valid,
	output res_item_t dout
);

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_RECORDS);
	localparam logic [CW-1:0] ONE = CW'(1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] i_q, j_q;
	rec_t          cur_q;

	logic          accept, fits;
	logic [CW-1:0] i_inc, j_inc;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	rec_t          wdata, rdata, new_rec;
	logic          swap;
	rec_t          keep, spill;

	assign accept = start && (state_q == ST_IDLE);
	assign fits   = count_q < CAP;
	assign i_inc  = i_q + ONE;
	assign j_inc  = j_q + ONE;
	assign busy   = state_q != ST_IDLE;

	assign new_rec.id    = din.student_id;
	assign new_rec.score = (din.score > SCORE_MAX) ? SCORE_MAX : din.score;

	rxsd_store #(
		.DEPTH(MAX_RECORDS),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	rxsd_cmpx u_cmpx (
		.held (cur_q),
		.cand (rdata),
		.swap (swap),
		.keep (keep),
		.spill(spill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = count_q[AW-1:0];
		wdata   = new_rec;
		raddr   = i_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					we = fits;
					if (din.last) begin
						state_d = ST_RD_I;
					end
				end
			end
			ST_RD_I: begin
				state_d = ST_LD_I;
			end
			ST_LD_I: begin
				state_d = (i_inc == count_q) ? ST_EMIT : ST_RD_J;
			end
			ST_RD_J: begin
				raddr   = j_q[AW-1:0];
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// Push the displaced record back into slot j.
				we      = swap;
				waddr   = j_q[AW-1:0];
				wdata   = spill;
				state_d = (j_inc == count_q) ? ST_EMIT : ST_RD_J;
			end
			ST_EMIT: begin
				state_d = (i_inc == count_q) ? ST_IDLE : ST_RD_I;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			if (accept) begin
				i_q <= '0;
				if (fits) begin
					count_q <= count_q + ONE;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_LD_I) begin
				j_q <= i_inc;
			end
			if (state_q == ST_CMP) begin
				j_q <= j_inc;
			end
			if (state_q == ST_EMIT) begin
				i_q <= i_inc;
				if (i_inc == count_q) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LD_I) begin
			cur_q <= rdata;
		end else if (state_q == ST_CMP) begin
			cur_q <= keep;
		end
	end

	assign dout_valid          = state_q == ST_EMIT;
	assign dout.student_id_res = cur_q.id;
	assign dout.score_res      = cur_q.score;
	assign dout.last_res       = i_inc == count_q;
	assign dout.overflow       = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("record count above capacity");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid && dout.last_res |=> !busy && count_q == '0 && !ovf_q)
		else $error("run did not end after final transaction");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> j_q > i_q && j_q < count_q)
		else $error("scan index out of range");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid |-> dout.score_res <= SCORE_MAX)
		else $error("score out of range on result");

endmodule
